// File: hw/rtl/ptp_pkg.sv
// ptp_pkg: shared types, widths and character codes of the polynomial term parser
`default_nettype none

package ptp_pkg;

  // accumulator widths
  localparam int COEFF_WIDTH = 32;
  localparam int EXP_WIDTH   = 16;
  localparam int CACC_WIDTH  = COEFF_WIDTH + 4;
  localparam int EACC_WIDTH  = EXP_WIDTH + 4;

  typedef logic [COEFF_WIDTH-1:0] coeff_t;
  typedef logic [EXP_WIDTH-1:0]   exp_t;
  typedef logic [CACC_WIDTH-1:0]  cacc_t;
  typedef logic [EACC_WIDTH-1:0]  eacc_t;

  // largest magnitudes a term may reach
  localparam cacc_t COEFF_NEG_MAX = cacc_t'(1) << (COEFF_WIDTH - 1);
  localparam cacc_t COEFF_POS_MAX = (cacc_t'(1) << (COEFF_WIDTH - 1)) - cacc_t'(1);
  localparam eacc_t EXP_MAX       = (eacc_t'(1) << EXP_WIDTH) - eacc_t'(1);

  // ascii codes
  localparam logic [7:0] CHAR_0     = 8'd48;
  localparam logic [7:0] CHAR_9     = 8'd57;
  localparam logic [7:0] CHAR_CARET = 8'h5E;
  localparam logic [7:0] CHAR_X     = 8'h78;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;

  // parser phases
  typedef enum logic [1:0] {
    PH_START   = 2'd0,
    PH_AFTER_X = 2'd1,
    PH_COEFF   = 2'd2,
    PH_EXP     = 2'd3
  } phase_t;

  // error codes
  typedef enum logic [2:0] {
    ERR_NONE        = 3'd0,
    ERR_INVALID     = 3'd1,
    ERR_MISSING_EXP = 3'd2,
    ERR_LONE_SIGN   = 3'd3,
    ERR_OVERFLOW    = 3'd4
  } err_t;

  // input transaction
  typedef struct packed {
    logic [7:0] character;
    logic       last_char;
  } in_item_t;

  // result transaction
  typedef struct packed {
    logic                          term_valid;
    logic signed [COEFF_WIDTH-1:0] coefficient;
    logic [EXP_WIDTH-1:0]          exponent;
    logic [2:0]                    error_code;
    logic                          end_of_expr;
  } out_item_t;

endpackage

`default_nettype wire

// File: hw/rtl/ptp_in_stage.sv
// ptp_in_stage: input register that holds one accepted character transaction
`default_nettype none

module ptp_in_stage (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire ptp_pkg::in_item_t in_data,
  output logic                   item_valid,
  output ptp_pkg::in_item_t      item,
  input  wire logic              item_take
);

  logic              valid_r;
  logic              valid_nxt;
  ptp_pkg::in_item_t data_r;

  // room when empty or when the held item moves on this cycle
  assign in_ready   = !valid_r || item_take;
  assign item_valid = valid_r;
  assign item       = data_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (item_take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= in_data;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/ptp_step.sv
// ptp_step: parser state registers and the per-character next-state logic
`default_nettype none

module ptp_step (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire ptp_pkg::in_item_t item,
  output ptp_pkg::out_item_t     res
);

  // outcome of closing the open term
  typedef struct packed {
    logic            emit;
    ptp_pkg::coeff_t coef;
    ptp_pkg::exp_t   expo;
    ptp_pkg::err_t   err;
  } close_t;

  ptp_pkg::phase_t phase_r, phase_nxt;
  logic            neg_r, neg_nxt;
  ptp_pkg::coeff_t mag_r, mag_nxt;
  logic            has_c_r, has_c_nxt;
  ptp_pkg::exp_t   exp_r, exp_nxt;
  logic            has_e_r, has_e_nxt;
  logic            halted_r, halted_nxt;

  logic [7:0]      c;
  logic            last;
  logic            is_digit;
  logic            is_sign;
  logic [3:0]      dig;
  ptp_pkg::cacc_t  c_acc;
  ptp_pkg::cacc_t  c_lim;
  ptp_pkg::eacc_t  e_acc;
  close_t          cl_cur;
  close_t          cl_end;
  ptp_pkg::err_t   err;
  close_t          term;

  function automatic close_t close_term(ptp_pkg::phase_t ph, logic ng, ptp_pkg::coeff_t mag,
                                        logic hc, ptp_pkg::exp_t ev, logic he);
    close_t r;
    r      = '0;
    r.err  = ptp_pkg::ERR_NONE;
    r.coef = ng ? ptp_pkg::coeff_t'(-mag) : mag;
    case (ph)
      ptp_pkg::PH_COEFF: begin
        if (!hc) begin
          r.err = ng ? ptp_pkg::ERR_LONE_SIGN : ptp_pkg::ERR_NONE;
        end else begin
          r.emit = (mag != '0);
        end
      end
      ptp_pkg::PH_AFTER_X: begin
        r.emit = (mag != '0);
        r.expo = ptp_pkg::exp_t'(1);
      end
      ptp_pkg::PH_EXP: begin
        if (!he) begin
          r.err = ptp_pkg::ERR_MISSING_EXP;
        end else begin
          r.emit = (mag != '0);
          r.expo = ev;
        end
      end
      default: begin
        r.emit = 1'b0;
      end
    endcase
    return r;
  endfunction

  // character classes and digit accumulation (times ten as two shifts)
  always_comb begin
    c        = item.character;
    last     = item.last_char;
    is_digit = c inside {[ptp_pkg::CHAR_0:ptp_pkg::CHAR_9]};
    is_sign  = (c == ptp_pkg::CHAR_PLUS) || (c == ptp_pkg::CHAR_MINUS);
    dig      = 4'(c - ptp_pkg::CHAR_0);
    c_acc    = (ptp_pkg::cacc_t'(mag_r) << 3) + (ptp_pkg::cacc_t'(mag_r) << 1)
             + ptp_pkg::cacc_t'(dig);
    c_lim    = neg_r ? ptp_pkg::COEFF_NEG_MAX : ptp_pkg::COEFF_POS_MAX;
    e_acc    = (ptp_pkg::eacc_t'(exp_r) << 3) + (ptp_pkg::eacc_t'(exp_r) << 1)
             + ptp_pkg::eacc_t'(dig);
    cl_cur   = close_term(phase_r, neg_r, mag_r, has_c_r, exp_r, has_e_r);
  end

  // next state and result
  always_comb begin
    phase_nxt  = phase_r;
    neg_nxt    = neg_r;
    mag_nxt    = mag_r;
    has_c_nxt  = has_c_r;
    exp_nxt    = exp_r;
    has_e_nxt  = has_e_r;
    halted_nxt = halted_r;
    err        = ptp_pkg::ERR_NONE;
    term       = '0;
    cl_end     = '0;

    if (!halted_r) begin
      if (is_sign && phase_r != ptp_pkg::PH_START) begin
        // sign closes the open term and opens the next one
        if (cl_cur.err != ptp_pkg::ERR_NONE) begin
          err = cl_cur.err;
        end else begin
          term      = cl_cur;
          neg_nxt   = (c == ptp_pkg::CHAR_MINUS);
          mag_nxt   = '0;
          has_c_nxt = 1'b0;
          exp_nxt   = '0;
          has_e_nxt = 1'b0;
          phase_nxt = ptp_pkg::PH_COEFF;
        end
      end else begin
        case (phase_r)
          ptp_pkg::PH_START: begin
            mag_nxt   = '0;
            exp_nxt   = '0;
            has_e_nxt = 1'b0;
            neg_nxt   = 1'b0;
            if (c == ptp_pkg::CHAR_MINUS) begin
              neg_nxt   = 1'b1;
              has_c_nxt = 1'b0;
              phase_nxt = ptp_pkg::PH_COEFF;
            end else if (c == ptp_pkg::CHAR_X) begin
              has_c_nxt = 1'b1;
              mag_nxt   = ptp_pkg::coeff_t'(1);
              phase_nxt = ptp_pkg::PH_AFTER_X;
            end else if (is_digit) begin
              has_c_nxt = 1'b1;
              mag_nxt   = ptp_pkg::coeff_t'(dig);
              phase_nxt = ptp_pkg::PH_COEFF;
            end else begin
              err = ptp_pkg::ERR_INVALID;
            end
          end
          ptp_pkg::PH_COEFF: begin
            if (c == ptp_pkg::CHAR_X) begin
              if (!has_c_r) begin
                mag_nxt = ptp_pkg::coeff_t'(1);
              end
              has_c_nxt = 1'b1;
              phase_nxt = ptp_pkg::PH_AFTER_X;
            end else if (is_digit) begin
              if (c_acc > c_lim) begin
                err = ptp_pkg::ERR_OVERFLOW;
              end else begin
                mag_nxt   = c_acc[ptp_pkg::COEFF_WIDTH-1:0];
                has_c_nxt = 1'b1;
              end
            end else begin
              err = ptp_pkg::ERR_INVALID;
            end
          end
          ptp_pkg::PH_AFTER_X: begin
            if (c == ptp_pkg::CHAR_CARET) begin
              if (last) begin
                err = ptp_pkg::ERR_MISSING_EXP;
              end else begin
                phase_nxt = ptp_pkg::PH_EXP;
              end
            end else begin
              err = ptp_pkg::ERR_INVALID;
            end
          end
          default: begin
            if (is_digit) begin
              if (e_acc > ptp_pkg::EXP_MAX) begin
                err = ptp_pkg::ERR_OVERFLOW;
              end else begin
                exp_nxt   = e_acc[ptp_pkg::EXP_WIDTH-1:0];
                has_e_nxt = 1'b1;
              end
            end else begin
              err = ptp_pkg::ERR_INVALID;
            end
          end
        endcase
      end

      // the final character closes whatever term is still open
      if (err == ptp_pkg::ERR_NONE && last) begin
        cl_end = close_term(phase_nxt, neg_nxt, mag_nxt, has_c_nxt, exp_nxt, has_e_nxt);
        err    = cl_end.err;
        if (cl_end.emit) begin
          term = cl_end;
        end
      end

      // an error drops the open term and halts until the end
      if (err != ptp_pkg::ERR_NONE) begin
        neg_nxt    = 1'b0;
        mag_nxt    = '0;
        has_c_nxt  = 1'b0;
        exp_nxt    = '0;
        has_e_nxt  = 1'b0;
        halted_nxt = 1'b1;
      end
    end

    // end of expression restarts the parser
    if (last) begin
      phase_nxt  = ptp_pkg::PH_START;
      neg_nxt    = 1'b0;
      mag_nxt    = '0;
      has_c_nxt  = 1'b0;
      exp_nxt    = '0;
      has_e_nxt  = 1'b0;
      halted_nxt = 1'b0;
    end

    res.term_valid  = term.emit;
    res.coefficient = term.emit ? signed'(term.coef) : '0;
    res.exponent    = term.emit ? term.expo : '0;
    res.error_code  = err;
    res.end_of_expr = last;
  end

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= ptp_pkg::PH_START;
      neg_r    <= 1'b0;
      mag_r    <= '0;
      has_c_r  <= 1'b0;
      exp_r    <= '0;
      has_e_r  <= 1'b0;
      halted_r <= 1'b0;
    end else if (en) begin
      phase_r  <= phase_nxt;
      neg_r    <= neg_nxt;
      mag_r    <= mag_nxt;
      has_c_r  <= has_c_nxt;
      exp_r    <= exp_nxt;
      has_e_r  <= has_e_nxt;
      halted_r <= halted_nxt;
    end
  end

  // halted stays until the final character
  a_halt_holds: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r && !(en && last) |=> halted_r)
    else $error("parser left halt before end of expression");

  // the final character always restarts the parser
  a_end_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    en && last |=> !halted_r && phase_r == ptp_pkg::PH_START && mag_r == '0)
    else $error("parser not restarted after end of expression");

  // a halted parser holds no open term
  a_halt_clear: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |-> mag_r == '0 && !has_c_r && exp_r == '0 && !has_e_r)
    else $error("open term kept while halted");

  // emitted terms are nonzero and halted input emits nothing
  a_term_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    en && res.term_valid |-> res.coefficient != '0 && !halted_r)
    else $error("zero or halted term emitted");

endmodule

`default_nettype wire

// File: hw/rtl/ptp_out_stage.sv
// ptp_out_stage: result register that holds one result transaction for the consumer
`default_nettype none

module ptp_out_stage (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               load,
  input  wire ptp_pkg::out_item_t res,
  output logic                    can_load,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output ptp_pkg::out_item_t      out_data
);

  logic               valid_r;
  logic               valid_nxt;
  ptp_pkg::out_item_t data_r;

  // free when empty or when the held result leaves this cycle
  assign can_load  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // result capture
  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= res;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/polynomial_term_parser.sv
// polynomial_term_parser: top level of the streaming polynomial term parser
// One ASCII character enters per transaction and exactly one result transaction
// leaves for it, in order. The block takes one character every clock cycle
// while the result side keeps up; each character is held in the input register
// and its result is loaded into the result register when that has room. The
// whole per-character update (phase change, times-ten digit add with overflow
// compare, term close) sits between those two registers. in_ready follows
// out_ready combinationally when both registers are full. A result carries a
// term when a nonzero term closes, an error code on the character that detects
// the error, and end_of_expr on the character flagged last_char, after which
// parsing starts afresh.
`default_nettype none

module polynomial_term_parser (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire ptp_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output ptp_pkg::out_item_t      out_data
);

  logic               item_valid;
  ptp_pkg::in_item_t  item;
  logic               can_load;
  logic               step_en;
  ptp_pkg::out_item_t res;

  // a held character moves on when the result register has room
  assign step_en = item_valid && can_load;

  ptp_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (step_en)
  );

  ptp_step u_step (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (step_en),
    .item  (item),
    .res   (res)
  );

  ptp_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step_en),
    .res       (res),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// File: tb/tb_polynomial_term_parser.sv
// tb_polynomial_term_parser: self-checking testbench of the streaming polynomial term parser
`timescale 1ns / 1ps

module tb_polynomial_term_parser;

  typedef logic [7:0] chr_t;

  // one queued input transaction with its lead-in gap and an optional drain wait
  typedef struct {
    ptp_pkg::in_item_t item;
    int                gap;
    bit                drain;
  } char_entry_t;

  localparam int CYCLE_LIMIT = 600000;
  localparam int LONG_HOLD   = 300;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  ptp_pkg::in_item_t  in_data   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  ptp_pkg::out_item_t out_data;

  char_entry_t        char_q[$];
  ptp_pkg::out_item_t parsed_q[$];

  int chars_queued   = 0;
  int chars_accepted = 0;
  int results_seen   = 0;
  int error_count    = 0;
  int cycle_count    = 0;
  bit drain_next     = 1'b0;
  bit in_taken       = 1'b0;
  bit out_taken      = 1'b0;
  int gap_cnt        = 0;
  int out_wait       = 0;
  int hold_left      = 0;
  int hold_stage     = 0;

  // parser state of the prediction
  ptp_pkg::phase_t st_phase;
  logic            st_neg;
  logic [63:0]     st_cmag;
  logic            st_cdig;
  logic            st_pending;
  logic [63:0]     st_eval;
  logic            st_edig;
  logic            st_halted;

  polynomial_term_parser u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // idle cycles drawn per transaction: none, uniform, or mostly none
  function automatic int pick_wait(input int mode);
    if (mode == 0) return 0;
    if (mode == 1) return $urandom_range(0, 17);
    return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 17) : 0;
  endfunction

  function automatic void clear_term();
    st_neg     = 1'b0;
    st_cmag    = '0;
    st_pending = 1'b0;
    st_cdig    = 1'b0;
    st_eval    = '0;
    st_edig    = 1'b0;
  endfunction

  function automatic void restart_parse();
    clear_term();
    st_phase  = ptp_pkg::PH_START;
    st_halted = 1'b0;
  endfunction

  // times-ten accumulate, refused when the limit would be passed
  function automatic logic add_digit(inout logic [63:0] acc, input logic [63:0] d,
                                     input logic [63:0] limit);
    if (acc > (limit - d) / 10) return 1'b0;
    acc = acc * 10 + d;
    return 1'b1;
  endfunction

  // zero coefficients are parsed but never reported
  function automatic void emit_term(inout ptp_pkg::out_item_t r, input logic [63:0] expo);
    logic [63:0] v;
    if (st_cmag == 0) return;
    v = st_neg ? (64'd0 - st_cmag) : st_cmag;
    r.term_valid  = 1'b1;
    r.coefficient = v[ptp_pkg::COEFF_WIDTH-1:0];
    r.exponent    = expo[ptp_pkg::EXP_WIDTH-1:0];
  endfunction

  // finish whatever term the current phase holds
  function automatic ptp_pkg::err_t close_term(inout ptp_pkg::out_item_t r);
    case (st_phase)
      ptp_pkg::PH_COEFF: begin
        if (!st_cdig) return st_neg ? ptp_pkg::ERR_LONE_SIGN : ptp_pkg::ERR_NONE;
        emit_term(r, 64'd0);
        return ptp_pkg::ERR_NONE;
      end
      ptp_pkg::PH_AFTER_X: begin
        emit_term(r, 64'd1);
        return ptp_pkg::ERR_NONE;
      end
      ptp_pkg::PH_EXP: begin
        if (!st_edig) return ptp_pkg::ERR_MISSING_EXP;
        emit_term(r, st_eval);
        return ptp_pkg::ERR_NONE;
      end
      default: return ptp_pkg::ERR_NONE;
    endcase
  endfunction

  // a sign closes the open term and opens the next one
  function automatic ptp_pkg::err_t take_sign(input chr_t c, inout ptp_pkg::out_item_t r);
    ptp_pkg::err_t err;
    err = close_term(r);
    if (err != ptp_pkg::ERR_NONE) return err;
    clear_term();
    st_pending = 1'b1;
    st_neg     = (c == ptp_pkg::CHAR_MINUS);
    st_phase   = ptp_pkg::PH_COEFF;
    return ptp_pkg::ERR_NONE;
  endfunction

  function automatic ptp_pkg::err_t take_char(input chr_t c, input logic last,
                                              inout ptp_pkg::out_item_t r);
    logic        sign;
    logic        dig;
    logic [63:0] d;
    logic [63:0] climit;
    sign   = (c == ptp_pkg::CHAR_PLUS) || (c == ptp_pkg::CHAR_MINUS);
    dig    = (c >= ptp_pkg::CHAR_0) && (c <= ptp_pkg::CHAR_9);
    d      = {56'd0, c} - {56'd0, ptp_pkg::CHAR_0};
    climit = (64'd1 << (ptp_pkg::COEFF_WIDTH - 1)) - (st_neg ? 64'd0 : 64'd1);
    case (st_phase)
      ptp_pkg::PH_START: begin
        // a leading plus is not allowed
        if (c == ptp_pkg::CHAR_MINUS) begin
          clear_term();
          st_pending = 1'b1;
          st_neg     = 1'b1;
          st_phase   = ptp_pkg::PH_COEFF;
        end else if (c == ptp_pkg::CHAR_X) begin
          clear_term();
          st_pending = 1'b1;
          st_cdig    = 1'b1;
          st_cmag    = 64'd1;
          st_phase   = ptp_pkg::PH_AFTER_X;
        end else if (dig) begin
          clear_term();
          st_pending = 1'b1;
          st_cdig    = 1'b1;
          st_cmag    = d;
          st_phase   = ptp_pkg::PH_COEFF;
        end else begin
          return ptp_pkg::ERR_INVALID;
        end
        return ptp_pkg::ERR_NONE;
      end
      ptp_pkg::PH_COEFF: begin
        if (sign) return take_sign(c, r);
        if (c == ptp_pkg::CHAR_X) begin
          if (!st_cdig) st_cmag = 64'd1;
          st_cdig  = 1'b1;
          st_phase = ptp_pkg::PH_AFTER_X;
          return ptp_pkg::ERR_NONE;
        end
        if (dig) begin
          if (!add_digit(st_cmag, d, climit)) return ptp_pkg::ERR_OVERFLOW;
          st_cdig = 1'b1;
          return ptp_pkg::ERR_NONE;
        end
        return ptp_pkg::ERR_INVALID;
      end
      ptp_pkg::PH_AFTER_X: begin
        if (sign) return take_sign(c, r);
        if (c == ptp_pkg::CHAR_CARET) begin
          if (last) return ptp_pkg::ERR_MISSING_EXP;
          st_phase = ptp_pkg::PH_EXP;
          return ptp_pkg::ERR_NONE;
        end
        return ptp_pkg::ERR_INVALID;
      end
      default: begin
        if (sign) return take_sign(c, r);
        if (dig) begin
          if (!add_digit(st_eval, d, (64'd1 << ptp_pkg::EXP_WIDTH) - 64'd1)) begin
            return ptp_pkg::ERR_OVERFLOW;
          end
          st_edig = 1'b1;
          return ptp_pkg::ERR_NONE;
        end
        return ptp_pkg::ERR_INVALID;
      end
    endcase
  endfunction

  // predicted result of one character, advancing the parser state
  function automatic ptp_pkg::out_item_t parse_char(input ptp_pkg::in_item_t it);
    ptp_pkg::out_item_t r;
    ptp_pkg::err_t      err;
    r   = '0;
    err = ptp_pkg::ERR_NONE;
    if (!st_halted) begin
      err = take_char(it.character, it.last_char, r);
      if (err == ptp_pkg::ERR_NONE && it.last_char) err = close_term(r);
      if (err != ptp_pkg::ERR_NONE) begin
        clear_term();
        st_halted = 1'b1;
      end
    end
    r.error_code = err;
    if (it.last_char) begin
      restart_parse();
      r.end_of_expr = 1'b1;
    end
    return r;
  endfunction

  // queue one expression, last_char on its final character
  task automatic push_expr(input chr_t t[$]);
    char_entry_t e;
    for (int i = 0; i < t.size(); i++) begin
      e.item.character = t[i];
      e.item.last_char = (i == t.size() - 1);
      e.gap            = pick_wait((chars_queued / 130) % 3);
      e.drain          = drain_next;
      drain_next       = 1'b0;
      char_q.insert(char_q.size(), e);
      chars_queued++;
    end
  endtask

  task automatic push_number(inout chr_t t[$], input longint unsigned v);
    string s;
    s = $sformatf("%0d", v);
    for (int i = 0; i < s.len(); i++) t.insert(t.size(), chr_t'(s[i]));
  endtask

  // one term: a sign (optional on the first term), optional coefficient digits, optional x and exponent
  task automatic build_term(inout chr_t t[$], input bit first);
    bit              has_x;
    int              k;
    longint unsigned v;
    if (first) begin
      if ($urandom_range(0, 1)) t.insert(t.size(), ptp_pkg::CHAR_MINUS);
    end else begin
      t.insert(t.size(), $urandom_range(0, 1) ? ptp_pkg::CHAR_PLUS : ptp_pkg::CHAR_MINUS);
    end
    has_x = ($urandom_range(0, 99) < 60);
    k     = $urandom_range(0, 9);
    if (!(has_x && k < 3)) begin
      if (k < 8) begin
        v = $urandom_range(0, 20);
      end else begin
        case ($urandom_range(0, 3))
          0:       v = 64'd2147483647;
          1:       v = 64'd2147483648;
          2:       v = $urandom;
          default: v = $urandom_range(100, 999999);
        endcase
      end
      push_number(t, v);
    end
    if (has_x) begin
      t.insert(t.size(), ptp_pkg::CHAR_X);
      if ($urandom_range(0, 1)) begin
        t.insert(t.size(), ptp_pkg::CHAR_CARET);
        k = $urandom_range(0, 9);
        if (k < 8) v = $urandom_range(0, 20);
        else if (k == 8) v = 64'd65535;
        else v = ($urandom_range(0, 1)) ? 64'd65536 : $urandom_range(0, 99999);
        push_number(t, v);
      end
    end
  endtask

  // stimulus: directed expressions, then random well-formed, broken and noise text
  initial begin
    string dir_text[5];
    chr_t  t[$];
    int    random_chars;
    int    r;
    int    nterms;
    bit    mid_drained;
    dir_text     = '{"-3x^2+x-7", "x-", "0x+", "x^", "x^70000"};
    random_chars = 0;
    mid_drained  = 1'b0;
    restart_parse();

    foreach (dir_text[i]) begin
      t.delete();
      for (int j = 0; j < dir_text[i].len(); j++) t.insert(t.size(), chr_t'(dir_text[i][j]));
      push_expr(t);
    end
    // leading plus then an ignored top byte; a lone zero byte
    t = '{ptp_pkg::CHAR_PLUS, 8'hFF};
    push_expr(t);
    t = '{8'h00};
    push_expr(t);

    drain_next = 1'b1;
    while (random_chars < 1900) begin
      t.delete();
      r = $urandom_range(0, 99);
      if (r < 85) begin
        nterms = $urandom_range(1, 6);
        for (int i = 0; i < nterms; i++) build_term(t, i == 0);
        if (r >= 70) begin
          case ($urandom_range(0, 5))
            0: t[$urandom_range(0, t.size() - 1)] = chr_t'($urandom_range(0, 255));
            1: t.insert($urandom_range(0, t.size()), chr_t'($urandom_range(0, 255)));
            2: t.insert(t.size(),
                        $urandom_range(0, 1) ? ptp_pkg::CHAR_PLUS : ptp_pkg::CHAR_MINUS);
            3: t.insert(t.size(), ptp_pkg::CHAR_CARET);
            4: t.push_front(ptp_pkg::CHAR_PLUS);
            default: t.insert($urandom_range(0, t.size()),
                              $urandom_range(0, 1) ? ptp_pkg::CHAR_PLUS : ptp_pkg::CHAR_MINUS);
          endcase
        end
      end else begin
        nterms = $urandom_range(1, 8);
        for (int i = 0; i < nterms; i++) t.insert(t.size(), chr_t'($urandom_range(0, 255)));
      end
      if (!mid_drained && random_chars > 950) begin
        drain_next  = 1'b1;
        mid_drained = 1'b1;
      end
      random_chars += t.size();
      push_expr(t);
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // wait for all transactions to pass, then a little latency margin
    while (chars_accepted != chars_queued) @(negedge clk);
    while (parsed_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // input driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_taken) begin
        in_taken = 1'b0;
        if (char_q.size() == 0) begin
          in_valid <= 1'b0;
        end else if (char_q[0].drain && parsed_q.size() != 0) begin
          in_valid <= 1'b0;
        end else if (gap_cnt < char_q[0].gap) begin
          gap_cnt++;
          in_valid <= 1'b0;
        end else begin
          in_data  <= char_q[0].item;
          in_valid <= 1'b1;
          char_q.pop_front();
          gap_cnt = 0;
        end
      end
    end
  end

  // result receiver with per-transaction stalls and long hold-offs
  always @(negedge clk) begin
    if (rst_n) begin
      if ((hold_stage == 0 && results_seen >= 400) ||
          (hold_stage == 1 && results_seen >= 1300)) begin
        hold_left = LONG_HOLD;
        hold_stage++;
      end
      if (out_taken) begin
        out_taken = 1'b0;
        out_wait  = pick_wait((results_seen / 150) % 3);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (out_wait > 0) begin
        out_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // monitor: check results, predict accepted characters, watch the cycle limit
  always @(posedge clk) begin
    ptp_pkg::out_item_t want;
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else if (rst_n) begin
      if (out_valid && out_ready) begin
        out_taken = 1'b1;
        results_seen++;
        if (parsed_q.size() == 0) begin
          $error("result transaction with none outstanding");
          error_count++;
        end else begin
          want = parsed_q.pop_front();
          if (want.term_valid !== out_data.term_valid) begin
            $error("term_valid: expected %0d, actual %0d", want.term_valid, out_data.term_valid);
            error_count++;
          end
          if (want.coefficient !== out_data.coefficient) begin
            $error("coefficient: expected %0d, actual %0d",
                   want.coefficient, out_data.coefficient);
            error_count++;
          end
          if (want.exponent !== out_data.exponent) begin
            $error("exponent: expected %0d, actual %0d", want.exponent, out_data.exponent);
            error_count++;
          end
          if (want.error_code !== out_data.error_code) begin
            $error("error_code: expected %0d, actual %0d", want.error_code, out_data.error_code);
            error_count++;
          end
          if (want.end_of_expr !== out_data.end_of_expr) begin
            $error("end_of_expr: expected %0d, actual %0d",
                   want.end_of_expr, out_data.end_of_expr);
            error_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        in_taken = 1'b1;
        chars_accepted++;
        parsed_q.insert(parsed_q.size(), parse_char(in_data));
      end
    end
  end

endmodule

// File: sim.f
hw/rtl/ptp_pkg.sv
hw/rtl/ptp_in_stage.sv
hw/rtl/ptp_step.sv
hw/rtl/ptp_out_stage.sv
hw/rtl/polynomial_term_parser.sv
tb/tb_polynomial_term_parser.sv
